>>> hdl/spq_pkg.sv
package spq_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [1:0] {
        FN_CLEAR  = 2'd0,
        FN_INSERT = 2'd1,
        FN_POP    = 2'd2,
        FN_NOP    = 2'd3
    } t_spq_func;

    // Fixed field widths of the stream words.
    localparam int unsigned SCORE_W = 16;
    localparam int unsigned ID_W    = 6;
    localparam int unsigned OCC_W   = 7;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned IN_W    = 24;
    localparam int unsigned OUT_W   = 32;

    // Command broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic do_ins;
        logic do_pop;
    } t_spq_cmd;

endpackage

>>> hdl/spq_cell.sv
module spq_cell #(
    parameter int unsigned KEY_BITS = 16,
    parameter int unsigned CW       = 7,
    parameter int unsigned INDEX    = 0
) (
    input  logic                     i_clk,
    input  spq_pkg::t_spq_cmd        i_cmd,
    input  logic [KEY_BITS-1:0]      i_new_key,
    input  logic [spq_pkg::ID_W-1:0] i_new_id,
    input  logic [CW-1:0]            i_count,
    input  logic                     i_prev_ge,
    input  logic [KEY_BITS-1:0]      i_prev_key,
    input  logic [spq_pkg::ID_W-1:0] i_prev_id,
    input  logic [KEY_BITS-1:0]      i_next_key,
    input  logic [spq_pkg::ID_W-1:0] i_next_id,
    output logic                     o_ge,
    output logic [KEY_BITS-1:0]      o_key,
    output logic [spq_pkg::ID_W-1:0] o_id
);
    import spq_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [ID_W-1:0]     r_id;
    logic [KEY_BITS-1:0] n_key;
    logic [ID_W-1:0]     n_id;
    logic                w_occ;

    // The cell holds an entry when its place lies below the fill count.
    assign w_occ = CW'(INDEX) < i_count;

    // A held key at least as large as the new one keeps its place.
    assign o_ge  = w_occ && ($signed(r_key) >= $signed(i_new_key));

    // Insert: stay, take the new entry, or take the left neighbour's.
    // Pop: take the right neighbour's entry.
    always_comb begin
        n_key = r_key;
        n_id  = r_id;
        if (i_cmd.do_ins) begin
            if (!o_ge) begin
                if (i_prev_ge) begin
                    n_key = i_new_key;
                    n_id  = i_new_id;
                end else begin
                    n_key = i_prev_key;
                    n_id  = i_prev_id;
                end
            end
        end else if (i_cmd.do_pop) begin
            n_key = i_next_key;
            n_id  = i_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_id  <= n_id;
    end

    assign o_key = r_key;
    assign o_id  = r_id;

endmodule

>>> hdl/sorted_priority_queue.sv
// Stable sorted priority queue holding up to DEPTH entries of a signed key and a
// 6-bit action id, kept in descending key order in a chain of cells; equal keys
// leave in arrival order. Every cell compares its key with the incoming one at the
// same time and shifts left or right by one place, so a clear, insert or pop needs no
// further pass: one word is accepted per cycle and its result word appears in the
// output register the cycle after. The result register frees the input side as the
// result is taken, so back-to-back words flow at full rate while the output is ready.
// An insert into a full queue is refused and flagged; a pop on an empty queue
// returns best_valid low. There is no clearing pass after reset.
module sorted_priority_queue #(
    parameter int unsigned DEPTH    = 64,
    parameter int unsigned KEY_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [15:0] score, [21:16] action_id, [22] can_do, [23] zero
    input  logic [spq_pkg::IN_W-1:0]     i_s_tdata,
    // [1:0] func
    input  logic [spq_pkg::FUNC_W-1:0]   i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [0] best_valid, [6:1] best_id, [22:7] best_score, [23] dropped,
    // [30:24] occupancy, [31] zero
    output logic [spq_pkg::OUT_W-1:0]    o_m_tdata
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                w_accept;
    t_spq_func           w_func;
    t_spq_cmd            w_cmd;
    logic [SCORE_W-1:0]  w_score;
    logic [ID_W-1:0]     w_in_id;
    logic                w_can_do;
    logic [SCORE_W+31:0] w_score_ext;
    logic [KEY_BITS-1:0] w_new_key;
    logic                w_full;
    logic                w_empty;
    logic                w_best_valid;
    logic                w_dropped;
    logic [ID_W-1:0]     w_best_id;
    logic [SCORE_W-1:0]  w_best_score;
    logic [KEY_BITS+31:0] w_key_ext;
    logic [CW+OCC_W-1:0] w_count_ext;
    logic [OUT_W-1:0]    w_result;

    logic [KEY_BITS-1:0] w_key [DEPTH];
    logic [ID_W-1:0]     w_id  [DEPTH];
    logic                w_ge  [DEPTH];

    // Input word decode; the key is the score cut or sign-extended to KEY_BITS.
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_func      = t_spq_func'(i_s_tuser);
    assign w_score     = i_s_tdata[SCORE_W-1:0];
    assign w_in_id     = i_s_tdata[SCORE_W +: ID_W];
    assign w_can_do    = i_s_tdata[SCORE_W+ID_W];
    assign w_score_ext = {{32{w_score[SCORE_W-1]}}, w_score};
    assign w_new_key   = w_score_ext[KEY_BITS-1:0];

    assign w_full  = r_count >= CW'(DEPTH);
    assign w_empty = r_count == '0;

    // Operation decode and next fill count.
    always_comb begin
        w_cmd        = '0;
        w_best_valid = 1'b0;
        w_dropped    = 1'b0;
        n_count      = r_count;
        case (w_func)
            FN_CLEAR: begin
                n_count = '0;
            end
            FN_INSERT: begin
                if (w_can_do) begin
                    if (w_full) begin
                        w_dropped = 1'b1;
                    end else begin
                        w_cmd.do_ins = w_accept;
                        n_count      = r_count + 1'b1;
                    end
                end
            end
            FN_POP: begin
                if (!w_empty) begin
                    w_cmd.do_pop = w_accept;
                    w_best_valid = 1'b1;
                    n_count      = r_count - 1'b1;
                end
            end
            FN_NOP: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Chain of cells; cell 0 holds the front of the queue.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                w_prev_ge;
        logic [KEY_BITS-1:0] w_prev_key;
        logic [ID_W-1:0]     w_prev_id;
        logic [KEY_BITS-1:0] w_next_key;
        logic [ID_W-1:0]     w_next_id;

        if (g == 0) begin : g_head
            assign w_prev_ge  = 1'b1;
            assign w_prev_key = '0;
            assign w_prev_id  = '0;
        end else begin : g_body
            assign w_prev_ge  = w_ge[g-1];
            assign w_prev_key = w_key[g-1];
            assign w_prev_id  = w_id[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_key = '0;
            assign w_next_id  = '0;
        end else begin : g_inner
            assign w_next_key = w_key[g+1];
            assign w_next_id  = w_id[g+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS),
            .CW       (CW),
            .INDEX    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_new_key  (w_new_key),
            .i_new_id   (w_in_id),
            .i_count    (r_count),
            .i_prev_ge  (w_prev_ge),
            .i_prev_key (w_prev_key),
            .i_prev_id  (w_prev_id),
            .i_next_key (w_next_key),
            .i_next_id  (w_next_id),
            .o_ge       (w_ge[g]),
            .o_key      (w_key[g]),
            .o_id       (w_id[g])
        );
    end

    // Result word assembly from the front cell.
    assign w_key_ext    = {{32{w_key[0][KEY_BITS-1]}}, w_key[0]};
    assign w_best_id    = w_best_valid ? w_id[0] : '0;
    assign w_best_score = w_best_valid ? w_key_ext[SCORE_W-1:0] : '0;
    assign w_count_ext  = {{OCC_W{1'b0}}, n_count};
    assign w_result     = {1'b0, w_count_ext[OCC_W-1:0], w_dropped, w_best_score,
                           w_best_id, w_best_valid};

    // Fill count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= w_result;
        end
    end

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> hdl/spq_chk.sv
module spq_chk #(
    parameter int unsigned DEPTH    = 64,
    parameter int unsigned KEY_BITS = 16
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic [spq_pkg::IN_W-1:0]   i_s_tdata,
    input logic [spq_pkg::FUNC_W-1:0] i_s_tuser,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [spq_pkg::OUT_W-1:0]  o_m_tdata
);
    import spq_pkg::*;

    // No result word is offered straight after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word offered after reset");

    // The reported occupancy never exceeds the queue depth.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[30:24] <= DEPTH))
        else $error("occupancy beyond depth");

    // A word is never both a popped entry and a refused insert.
    a_pop_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[23]))
        else $error("pop and drop flagged together");

    // A stalled result word stays offered and unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result word changed");

    // A stalled output blocks the input side.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while result word stalled");

endmodule

bind sorted_priority_queue spq_chk #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
) u_spq_chk (.*);

>>> dv/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int unsigned DEPTH        = 64;
    localparam int unsigned KEY_BITS     = 16;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned RANDOM_WORDS = 1680;

    // Pacing regimes of the two stream sides.
    typedef enum logic [2:0] {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH,
        PACE_HOLD
    } t_pace;

    // One input word with the pacing it is sent under.
    typedef struct {
        t_spq_func   func;
        logic [15:0] score;
        logic [5:0]  action_id;
        logic        can_do;
        t_pace       pace;
    } t_cmd;

    // One result word, split into its fields.
    typedef struct packed {
        logic        best_valid;
        logic [5:0]  best_id;
        logic [15:0] best_score;
        logic        dropped;
        logic [6:0]  occupancy;
    } t_outcome;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // [15:0] score, [21:16] action_id, [22] can_do, [23] zero
    logic [IN_W-1:0]       i_s_tdata  = '0;
    // [1:0] func
    logic [FUNC_W-1:0]     i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [0] best_valid, [6:1] best_id, [22:7] best_score, [23] dropped,
    // [30:24] occupancy, [31] zero
    logic [OUT_W-1:0]      o_m_tdata;

    t_cmd        cmd_backlog[$];
    t_outcome    pending_results[$];
    t_cmd        word_on_bus;
    t_pace       pace_now   = PACE_FREE;
    t_pace       fill_pace  = PACE_FREE;
    int unsigned live_words = 0;
    int unsigned hold_left;
    logic        hold_done;
    int unsigned quiet_cycles;
    int unsigned n_fail = 0;

    // Shadow copy of the queue contents, front entry at index 0.
    logic [15:0] shadow_score[DEPTH];
    logic [5:0]  shadow_id[DEPTH];
    int unsigned shadow_count = 0;

    sorted_priority_queue #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Applies one operation to the shadow queue and returns the word it should produce.
    function automatic t_outcome queue_step(t_cmd c);
        t_outcome    r;
        int unsigned pos;
        int unsigned k;
        r = '0;
        case (c.func)
            FN_CLEAR: begin
                shadow_count = 0;
            end
            FN_INSERT: begin
                if (c.can_do) begin
                    if (shadow_count >= DEPTH) begin
                        r.dropped = 1'b1;
                    end else begin
                        // Stable placement: after every entry with a key not below the new one.
                        pos = 0;
                        while (pos < shadow_count &&
                               $signed(shadow_score[pos]) >= $signed(c.score))
                            pos++;
                        for (k = shadow_count; k > pos; k--) begin
                            shadow_score[k] = shadow_score[k-1];
                            shadow_id[k]    = shadow_id[k-1];
                        end
                        shadow_score[pos] = c.score;
                        shadow_id[pos]    = c.action_id;
                        shadow_count++;
                    end
                end
            end
            FN_POP: begin
                if (shadow_count > 0) begin
                    r.best_valid = 1'b1;
                    r.best_id    = shadow_id[0];
                    r.best_score = shadow_score[0];
                    for (k = 1; k < shadow_count; k++) begin
                        shadow_score[k-1] = shadow_score[k];
                        shadow_id[k-1]    = shadow_id[k];
                    end
                    shadow_count--;
                end
            end
            default: ;
        endcase
        r.occupancy = 7'(shadow_count);
        return r;
    endfunction

    function automatic int unsigned sender_gap_pct(t_pace p);
        case (p)
            PACE_SRC_IDLE: return 87;
            PACE_BOTH:     return 33;
            default:       return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct(t_pace p);
        case (p)
            PACE_SNK_STALL: return 87;
            PACE_BOTH:      return 33;
            default:        return 0;
        endcase
    endfunction

    // Keys biased towards the extremes and towards a few shared values, so ties are common.
    function automatic logic [15:0] pick_key();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h7FFF;
        if (r == 1)
            return 16'h8000;
        if (r <= 4)
            return 16'((int'($urandom_range(6)) - 3) * 256);
        return 16'($urandom);
    endfunction

    task automatic add_cmd(t_spq_func f, logic [15:0] s, logic [5:0] id, logic cd);
        t_cmd c;
        c.func      = f;
        c.score     = s;
        c.action_id = id;
        c.can_do    = cd;
        c.pace      = fill_pace;
        cmd_backlog.push_back(c);
        // Ignored words do not count towards the stimulus length.
        if (f == FN_CLEAR || f == FN_POP || (f == FN_INSERT && cd))
            live_words++;
    endtask

    // Stimulus, end of run and final verdict.
    initial begin
        int unsigned seg;
        int unsigned n;
        int unsigned r;
        int unsigned j;

        // Directed opening: empty queue, extreme keys, ties, ignored and unused operations.
        add_cmd(FN_POP,    16'h0000, 6'd0,  1'b1);
        add_cmd(FN_NOP,    16'hFFFF, 6'd63, 1'b1);
        add_cmd(FN_CLEAR,  16'h0000, 6'd0,  1'b0);
        add_cmd(FN_INSERT, 16'h7FFF, 6'd63, 1'b1);
        add_cmd(FN_INSERT, 16'h8000, 6'd0,  1'b1);
        add_cmd(FN_INSERT, 16'h0000, 6'd21, 1'b1);
        add_cmd(FN_INSERT, 16'h0100, 6'd5,  1'b1);
        add_cmd(FN_INSERT, 16'h0100, 6'd6,  1'b1);
        add_cmd(FN_INSERT, 16'h0100, 6'd7,  1'b1);
        add_cmd(FN_INSERT, 16'hFFFF, 6'd42, 1'b1);
        add_cmd(FN_INSERT, 16'h7FFF, 6'd1,  1'b0);
        add_cmd(FN_NOP,    16'h0000, 6'd0,  1'b0);
        add_cmd(FN_POP,    16'h0000, 6'd0,  1'b0);
        add_cmd(FN_POP,    16'h0000, 6'd0,  1'b0);
        add_cmd(FN_POP,    16'h0000, 6'd0,  1'b0);
        add_cmd(FN_CLEAR,  16'h7FFF, 6'd63, 1'b1);
        add_cmd(FN_POP,    16'h0000, 6'd0,  1'b1);
        add_cmd(FN_INSERT, 16'h0080, 6'd9,  1'b1);
        add_cmd(FN_INSERT, 16'hFF80, 6'd10, 1'b1);
        add_cmd(FN_POP,    16'h0000, 6'd0,  1'b1);
        add_cmd(FN_POP,    16'h0000, 6'd0,  1'b1);
        add_cmd(FN_POP,    16'h0000, 6'd0,  1'b1);

        // Random part built from fill, drain, mixed and lone-clear stretches; the first one tries to overfill.
        live_words = 0;
        seg = 0;
        while (live_words < RANDOM_WORDS) begin
            if (live_words < 250)       fill_pace = PACE_FREE;
            else if (live_words < 600)  fill_pace = PACE_SRC_IDLE;
            else if (live_words < 950)  fill_pace = PACE_SNK_STALL;
            else if (live_words < 1300) fill_pace = PACE_BOTH;
            else if (live_words < 1400) fill_pace = PACE_HOLD;
            else                        fill_pace = PACE_FREE;

            r = (seg == 0) ? 0 : $urandom_range(9);
            seg++;
            if (r <= 2) begin
                n = (seg == 1) ? 70 : $urandom_range(10, 75);
                for (j = 0; j < n; j++)
                    add_cmd(FN_INSERT, pick_key(), 6'($urandom),
                            $urandom_range(19) != 0);
            end else if (r <= 4) begin
                n = $urandom_range(5, 70);
                for (j = 0; j < n; j++)
                    add_cmd(FN_POP, 16'($urandom), 6'($urandom), 1'($urandom));
            end else if (r <= 8) begin
                n = $urandom_range(10, 40);
                for (j = 0; j < n; j++) begin
                    r = $urandom_range(99);
                    if (r < 2)
                        add_cmd(FN_CLEAR, 16'($urandom), 6'($urandom), 1'($urandom));
                    else if (r < 50)
                        add_cmd(FN_INSERT, pick_key(), 6'($urandom),
                                $urandom_range(9) != 0);
                    else if (r < 92)
                        add_cmd(FN_POP, 16'($urandom), 6'($urandom), 1'($urandom));
                    else
                        add_cmd(FN_NOP, 16'($urandom), 6'($urandom), 1'($urandom));
                end
            end else begin
                add_cmd(FN_CLEAR, 16'($urandom), 6'($urandom), 1'($urandom));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every word sent, every result seen, then an idle tail before the verdict.
        while (cmd_backlog.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("sorted_priority_queue: match");
        end else begin
            $display("sorted_priority_queue: mismatch");
        end
        $finish;
    end

    // Sender: predicts each accepted word, then offers the next one or idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                pending_results.push_back(queue_step(word_on_bus));
            if (!i_s_tvalid || o_s_tready) begin
                if (cmd_backlog.size() != 0 &&
                    $urandom_range(99) >= sender_gap_pct(cmd_backlog[0].pace)) begin
                    word_on_bus = cmd_backlog.pop_front();
                    i_s_tdata   <= {1'b0, word_on_bus.can_do, word_on_bus.action_id,
                                    word_on_bus.score};
                    i_s_tuser   <= word_on_bus.func;
                    pace_now    <= word_on_bus.pace;
                    i_s_tvalid  <= 1'b1;
                end else begin
                    i_s_tvalid  <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off when the hold stretch starts, random stalls otherwise.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end else if (pace_now == PACE_HOLD && !hold_done) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= $urandom_range(99) >= receiver_stall_pct(pace_now);
        end
    end

    // Result checker: every taken word against the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[0], o_m_tdata[6:1], o_m_tdata[22:7], o_m_tdata[23],
                   o_m_tdata[30:24]};
            if (pending_results.size() == 0) begin
                $error("result word with no prediction waiting: %h", o_m_tdata);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (got.best_valid !== want.best_valid) begin
                    $error("best_valid: expected %0d, got %0d", want.best_valid,
                           got.best_valid);
                    n_fail++;
                end
                if (got.best_id !== want.best_id) begin
                    $error("best_id: expected %0d, got %0d", want.best_id, got.best_id);
                    n_fail++;
                end
                if (got.best_score !== want.best_score) begin
                    $error("best_score: expected %0d, got %0d", $signed(want.best_score),
                           $signed(got.best_score));
                    n_fail++;
                end
                if (got.dropped !== want.dropped) begin
                    $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
                    n_fail++;
                end
                if (got.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           got.occupancy);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: too long without a word moving on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("sorted_priority_queue: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
